@@ hw/rtl/hrinv_pkg.sv @@
package hrinv_pkg;

  // Field widths fixed by the stream and register formats
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned BASE_W    = 8;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned ADDR_W    = 3;

  // Index bits consumed per cycle by the digit divider
  localparam int unsigned DIV_CHUNK = 4;

  localparam int unsigned DEF_INDEX_BITS    = 32;
  localparam int unsigned DEF_FRACTION_BITS = 32;

  localparam logic [BASE_W-1:0] BASE_RESET = 8'd2;
  localparam logic [BASE_W-1:0] BASE_MIN   = 8'd2;

  // Register index, taken from paddr above the byte offset
  localparam logic [ADDR_W-3:0] REG_IDX_RADIX = '0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DIGIT,
    S_FRAC,
    S_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic div_init;
    logic div_step;
    logic digit_upd;
    logic frac_init;
    logic frac_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic idx_zero;
  } stat_t;

endpackage

@@ hw/rtl/hrinv_ctrl.sv @@
module hrinv_ctrl import hrinv_pkg::*; #(
  parameter int unsigned INDEX_BITS    = DEF_INDEX_BITS,
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam int unsigned NCHUNK  = (INDEX_BITS + DIV_CHUNK - 1) / DIV_CHUNK;
  localparam int unsigned CNT_MAX = (NCHUNK > FRACTION_BITS) ? NCHUNK : FRACTION_BITS;
  localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NCHUNK - 1);
  localparam logic [CNT_W-1:0] FRAC_LAST = CNT_W'(FRACTION_BITS - 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CHECK;
      S_CHECK: state_d = stat_i.idx_zero ? S_FRAC : S_DIV;
      S_DIV:   if (cnt_q == DIV_LAST) state_d = S_DIGIT;
      S_DIGIT: state_d = S_CHECK;
      S_FRAC:  if (cnt_q == FRAC_LAST) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.start  = in_valid_i;
      end
      S_CHECK: begin
        cmd_o.frac_init = stat_i.idx_zero;
        cmd_o.div_init  = !stat_i.idx_zero;
      end
      S_DIV:   cmd_o.div_step  = 1'b1;
      S_DIGIT: cmd_o.digit_upd = 1'b1;
      S_FRAC:  cmd_o.frac_step = 1'b1;
      S_OUT:   cmd_o.out_load  = out_free;
      default: cmd_o = '0;
    endcase
  end

  // Step counter, shared by the divider chunks and the fraction bits
  always_comb begin
    if (state_q == S_DIV || state_q == S_FRAC) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else begin
      cnt_d = '0;
    end
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/hrinv_dpath.sv @@
module hrinv_dpath import hrinv_pkg::*; #(
  parameter int unsigned INDEX_BITS    = DEF_INDEX_BITS,
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic              clk_i,
  input  logic [BASE_W-1:0] base_i,
  input  logic [DATA_W-1:0] idx_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  output logic [DATA_W-1:0] frac_o
);

  localparam int unsigned NCHUNK = (INDEX_BITS + DIV_CHUNK - 1) / DIV_CHUNK;
  localparam int unsigned DIV_W  = NCHUNK * DIV_CHUNK;
  // base^K is at most index * base, so it fits in INDEX_BITS + BASE_W bits
  localparam int unsigned DEN_W  = INDEX_BITS + BASE_W;

  logic [INDEX_BITS-1:0]    idx_q;
  logic [DIV_W-1:0]         div_sh_q;
  logic [BASE_W-1:0]        dig_q;
  logic [DEN_W-1:0]         rev_q, den_q, rem_q;
  logic [FRACTION_BITS-1:0] q_q;
  logic [DATA_W-1:0]        frac_q;

  logic [DIV_W-1:0]         div_sh_nxt;
  logic [BASE_W-1:0]        dig_nxt;
  logic [DEN_W+BASE_W-1:0]  rev_prod, den_prod;
  logic [DEN_W-1:0]         rev_nxt;
  logic [DEN_W:0]           rem_sh, rem_diff;
  logic [DEN_W-1:0]         rem_nxt;
  logic                     q_bit;

  // Restoring division of the index by the base, DIV_CHUNK bits per cycle.
  // Quotient bits shift in at the bottom as dividend bits leave the top.
  always_comb begin
    logic [DIV_W-1:0]  sh;
    logic [BASE_W-1:0] r;
    logic [BASE_W:0]   t;
    logic [BASE_W:0]   d;
    sh = div_sh_q;
    r  = dig_q;
    for (int k = 0; k < DIV_CHUNK; k++) begin
      t = {r, sh[DIV_W-1]};
      d = t - {1'b0, base_i};
      if (t >= {1'b0, base_i}) begin
        r  = d[BASE_W-1:0];
        sh = {sh[DIV_W-2:0], 1'b1};
      end else begin
        r  = t[BASE_W-1:0];
        sh = {sh[DIV_W-2:0], 1'b0};
      end
    end
    div_sh_nxt = sh;
    dig_nxt    = r;
  end

  // Digit append: R = R*b + digit, D = D*b
  assign rev_prod = rev_q * base_i;
  assign den_prod = den_q * base_i;
  assign rev_nxt  = rev_prod[DEN_W-1:0] + DEN_W'(dig_q);

  // One quotient bit of R / D per cycle
  assign rem_sh   = {rem_q, 1'b0};
  assign rem_diff = rem_sh - {1'b0, den_q};
  assign q_bit    = (rem_sh >= {1'b0, den_q});
  assign rem_nxt  = q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      idx_q <= INDEX_BITS'(idx_i);
      rev_q <= '0;
      den_q <= DEN_W'(1);
    end
    if (cmd_i.div_init) begin
      div_sh_q <= DIV_W'(idx_q);
      dig_q    <= '0;
    end
    if (cmd_i.div_step) begin
      div_sh_q <= div_sh_nxt;
      dig_q    <= dig_nxt;
    end
    if (cmd_i.digit_upd) begin
      rev_q <= rev_nxt;
      den_q <= den_prod[DEN_W-1:0];
      idx_q <= INDEX_BITS'(div_sh_q);
    end
    if (cmd_i.frac_init) begin
      rem_q <= rev_q;
      q_q   <= '0;
    end
    if (cmd_i.frac_step) begin
      rem_q <= rem_nxt;
      q_q   <= {q_q[FRACTION_BITS-2:0], q_bit};
    end
    if (cmd_i.out_load) begin
      frac_q <= DATA_W'(q_q);
    end
  end

  assign stat_o.idx_zero = (idx_q == '0);
  assign frac_o          = frac_q;

endmodule

@@ hw/rtl/halton_radical_inverse_core.sv @@
// Halton radical inverse core.
// Input stream: one beat per index (s_axis_tdata = sample_index). Output
// stream: one beat per index (m_axis_tdata = fraction), the base-b digits of
// the index mirrored about the radix point as an unsigned 0.32 fraction,
// truncated. radix_base sits at APB byte address 0; 0 and 1 act as base 2.
// Write it only while the core is idle.
// Each base-b digit of the index is one pass of a 4-bit-per-cycle divider by
// the base, then the fraction comes out of a one-bit-per-cycle long division
// R / b^K and is loaded into the output register.
// One index is worked at a time; s_axis_tready is high while the core is idle,
// so a new index is taken only once the last result is in the output register.
// The result sits in an output register, so a stalled receiver holds the beat
// there while the next index is already accepted and computed; the core then
// waits until the register is free.
// Reset clears the controller and the output valid, and sets radix_base to 2.
module halton_radical_inverse_core import hrinv_pkg::*; #(
  parameter int unsigned INDEX_BITS    = DEF_INDEX_BITS,
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,

  // Index stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] sample_index

  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] fraction

  // Register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [BASE_W-1:0] base_q;
  logic [BASE_W-1:0] eff_base;
  logic              reg_hit;
  logic              reg_wr;
  cmd_t              cmd;
  stat_t             stat;

  // Register decode: word index above the byte offset
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_IDX_RADIX);
  assign reg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? APB_DW'(base_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (reg_wr && reg_hit) begin
      base_q <= pwdata[BASE_W-1:0];
    end
  end

  // Bases below two are meaningless; clamp to two
  assign eff_base = (base_q < BASE_MIN) ? BASE_MIN : base_q;

  hrinv_ctrl #(
    .INDEX_BITS    (INDEX_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  hrinv_dpath #(
    .INDEX_BITS    (INDEX_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk_i  (clk_i),
    .base_i (eff_base),
    .idx_i  (s_axis_tdata),
    .cmd_i  (cmd),
    .stat_o (stat),
    .frac_o (m_axis_tdata)
  );

endmodule

@@ tb/tb_halton_radical_inverse_core.sv @@
`timescale 1ns / 1ps

module tb_halton_radical_inverse_core;
  import hrinv_pkg::*;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RESET_CYCLES = 10;
  // Covers the worst compute plus the longest gap and stall, then margin.
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned TAIL_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned BURST_ITEMS  = 120;

  typedef struct {
    logic [DATA_W-1:0] sample_index;
    logic [BASE_W-1:0] base;
    logic [DATA_W-1:0] fraction;
  } fraction_exp_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata;    // [31:0] sample_index
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [DATA_W-1:0] m_axis_tdata;    // [31:0] fraction
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  fraction_exp_t     fraction_q[$];
  logic [BASE_W-1:0] radix_shadow;    // mirror of radix_base as the DUT holds it
  bit                tx_gaps_on;
  bit                rx_stalls_on;
  int unsigned       n_index_sent;
  int unsigned       n_fraction_seen;
  int unsigned       n_mismatch;
  int unsigned       n_base_writes;
  int unsigned       idle_cycles;
  int unsigned       rx_stall_left;

  halton_radical_inverse_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Radical inverse: mirror the base-b digits of idx into R, then produce
  // the 32 fraction bits of R / b^K by restoring long division (truncated).
  function automatic logic [DATA_W-1:0] halton_fraction(logic [DATA_W-1:0] idx,
                                                        logic [BASE_W-1:0] base_reg);
    longint unsigned b, n, mirrored, denom, rem;
    logic [DATA_W-1:0] q;
    int i;
    b        = (base_reg < BASE_MIN) ? BASE_MIN : base_reg;  // 0 and 1 act as 2
    n        = idx;
    mirrored = 0;
    denom    = 1;
    while (n > 0) begin
      mirrored = mirrored * b + (n % b);
      denom    = denom * b;
      n        = n / b;
    end
    rem = mirrored;
    q   = '0;
    for (i = 0; i < DEF_FRACTION_BITS; i++) begin
      rem = rem << 1;
      q   = {q[DATA_W-2:0], 1'b0};
      if (rem >= denom) begin
        rem  = rem - denom;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sender gap: mostly back-to-back, sometimes short, rarely long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!tx_gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Index mix: full range, small counts, powers of the base and one below them
  // (digit-count edges), heavy high-bit patterns and right-shifted randoms.
  function automatic logic [DATA_W-1:0] pick_index(logic [BASE_W-1:0] base_reg);
    longint unsigned b, p;
    int unsigned k;
    b = (base_reg < BASE_MIN) ? BASE_MIN : base_reg;
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2:    return $urandom_range(0, 1023);
      3: begin
        p = 1;
        k = $urandom_range(1, 32);
        repeat (k) if (p * b <= 64'hFFFF_FFFF) p = p * b;
        return DATA_W'(p - $urandom_range(0, 1));
      end
      4:    return $urandom | 32'h8000_0000;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // One index beat; the expectation is queued at the accepting edge.
  task automatic send_index(input logic [DATA_W-1:0] idx);
    fraction_exp_t e;
    repeat (pick_gap()) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= idx;
    do @(posedge clk_i); while (!s_axis_tready);
    e.sample_index = idx;
    e.base         = radix_shadow;
    e.fraction     = halton_fraction(idx, radix_shadow);
    fraction_q.push_back(e);
    n_index_sent++;
  endtask

  // Drop valid and wait until every queued fraction has come back.
  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (fraction_q.size() != 0) @(posedge clk_i);
  endtask

  // APB write of radix_base; only called with the core drained.
  // Upper data bits are random: only the low byte is the register.
  task automatic write_radix_base(input logic [BASE_W-1:0] base);
    wait_results_drained();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_IDX_RADIX, 2'b00};
    pwdata  <= {(APB_DW - BASE_W)'($urandom_range(0, (1 << (APB_DW - BASE_W)) - 1)),
                base};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    radix_shadow = base;
    n_base_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Receiver: random stalls, mostly short, a few long; off when disabled.
  always @(negedge clk_i) begin
    if (!rx_stalls_on) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4:  rx_stall_left = $urandom_range(1, 3);
        5:              rx_stall_left = $urandom_range(20, 60);
        default:        rx_stall_left = 0;
      endcase
      m_axis_tready <= (rx_stall_left == 0);
    end
  end

  // Result checker: compare each accepted beat against the oldest expectation.
  always @(posedge clk_i) begin
    fraction_exp_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_fraction_seen++;
      if (fraction_q.size() == 0) begin
        n_mismatch++;
        $error("fraction beat with nothing expected: actual %h", m_axis_tdata);
      end else begin
        e = fraction_q.pop_front();
        if (m_axis_tdata !== e.fraction) begin
          n_mismatch++;
          $error("fraction mismatch (index %h, base %0d): expected %h, actual %h",
                 e.sample_index, e.base, e.fraction, m_axis_tdata);
        end
      end
    end
  end

  // Watchdog: any accepted beat on either stream restarts the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_halton_radical_inverse_core: FAIL");
        $finish;
      end
    end
  end

  // Reset base is 2: zero, small indices, the all-ones index, the top bit alone
  // and the alternating patterns that mirror onto each other.
  task automatic test_reset_base();
    send_index(32'h0000_0000);
    send_index(32'h0000_0001);
    send_index(32'h0000_0002);
    send_index(32'h0000_0003);
    send_index(32'hFFFF_FFFF);
    send_index(32'h8000_0000);
    send_index(32'hAAAA_AAAA);
    send_index(32'h5555_5555);
  endtask

  // Base register extremes, including the meaningless bases 0 and 1.
  task automatic test_base_extremes();
    write_radix_base(8'd0);
    send_index(32'h0000_0001);
    send_index(32'hFFFF_FFFF);
    write_radix_base(8'd1);
    send_index(32'h0000_0006);
    write_radix_base(8'd255);
    send_index(32'd254);
    send_index(32'd255);
    send_index(32'd256);
    send_index(32'hFFFF_FFFF);
    write_radix_base(8'd3);
    send_index(32'd3486784401);        // 3^20, one digit more than 3^20 - 1
    send_index(32'd3486784400);
    send_index(32'hFFFF_FFFF);
    write_radix_base(8'd254);
    send_index(32'h0000_0000);
    send_index(32'h7FFF_FFFF);
  endtask

  // Random phases, each with its own base; the sender drains now and then.
  task automatic test_random_bases();
    logic [BASE_W-1:0] primes[] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37,
                                     41, 43, 47, 97, 101, 127, 131, 211, 251};
    int unsigned sent, phase_len;
    logic [BASE_W-1:0] base;
    sent = 0;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       base = BASE_W'($urandom_range(0, 255));
        default: base = primes[$urandom_range(0, primes.size() - 1)];
      endcase
      write_radix_base(base);
      phase_len = $urandom_range(60, 140);
      repeat (phase_len) begin
        send_index(pick_index(radix_shadow));
        sent++;
        if ($urandom_range(0, 49) == 0) wait_results_drained();
      end
    end
  endtask

  // No idling on either side: full-rate stream in base 2 and base 251.
  task automatic test_back_to_back();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    write_radix_base(8'd2);
    repeat (BURST_ITEMS / 2) send_index(pick_index(radix_shadow));
    write_radix_base(8'd251);
    repeat (BURST_ITEMS / 2) send_index(pick_index(radix_shadow));
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    m_axis_tready   = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    radix_shadow    = BASE_RESET;
    tx_gaps_on      = 1'b1;
    rx_stalls_on    = 1'b1;
    n_index_sent    = 0;
    n_fraction_seen = 0;
    n_mismatch      = 0;
    n_base_writes   = 0;
    idle_cycles     = 0;
    rx_stall_left   = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_base();
    test_base_extremes();
    test_random_bases();
    test_back_to_back();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Checked %0d fractions for %0d indices over %0d base writes",
             n_fraction_seen, n_index_sent, n_base_writes);
    $display("  (bases 0, 1, 2, 3, 254, 255 and random; %0d mismatches)", n_mismatch);
    if (n_mismatch == 0 && fraction_q.size() == 0) begin
      $display("tb_halton_radical_inverse_core: PASS");
    end else begin
      $display("tb_halton_radical_inverse_core: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/hrinv_pkg.sv
hw/rtl/hrinv_ctrl.sv
hw/rtl/hrinv_dpath.sv
hw/rtl/halton_radical_inverse_core.sv
tb/tb_halton_radical_inverse_core.sv
